// ----- sv/asp_pkg.sv -----
// ============================================================================
// asp_pkg
// Shared types and constants for the ANSI SGR colour parser.
// ============================================================================
package asp_pkg;

    // Field widths of the console channels.
    localparam int BYTE_W   = 8;
    localparam int COLOUR_W = 32;

    // Character codes recognised by the parser.
    localparam logic [BYTE_W-1:0] ESC_CODE   = 8'h1B;
    localparam logic [BYTE_W-1:0] CSI_OPEN   = 8'h5B;   // '['
    localparam logic [BYTE_W-1:0] SGR_FINAL  = 8'h6D;   // 'm'
    localparam logic [BYTE_W-1:0] PARAM_SEP  = 8'h3B;   // ';'
    localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'h30;   // '0'
    localparam logic [BYTE_W-1:0] DIGIT_NINE = 8'h39;   // '9'

    // SGR codes handled by the final walk.
    localparam int SGR_RESET = 0;
    localparam int SGR_FORE  = 38;
    localparam int SGR_BACK  = 48;
    localparam int SGR_RGB   = 2;

    // Colour constants, ARGB 8:8:8:8.
    localparam logic [COLOUR_W-1:0] WHITE_ARGB  = 32'hFFFF_FFFF;
    localparam logic [COLOUR_W-1:0] BLACK_ARGB  = 32'h0000_0000;
    localparam logic [COLOUR_W-1:0] OPAQUE_ARGB = 32'hFF00_0000;

    // Commands from the sequencer to the parameter store.
    typedef struct packed {
        logic wr_en;    // write the read-modify-write result back
        logic clear;    // a new sequence starts: all entries read as zero
    } store_cmd_t;

    // One glyph word as it leaves the parser.
    typedef struct packed {
        logic [BYTE_W-1:0]   glyph_code;
        logic [COLOUR_W-1:0] fore_colour;
        logic [COLOUR_W-1:0] back_colour;
    } glyph_t;

endpackage

// ----- sv/asp_if.sv -----
// ============================================================================
// asp_if
// Valid/ready channels: text bytes in, glyph words with colours out.
// ============================================================================
interface asp_byte_if;
    import asp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface asp_glyph_if;
    import asp_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   glyph_code;
    logic [COLOUR_W-1:0] fore_colour;
    logic [COLOUR_W-1:0] back_colour;

    modport source (output valid, output glyph_code, output fore_colour,
                    output back_colour, input ready);
    modport sink   (input valid, input glyph_code, input fore_colour,
                    input back_colour, output ready);
endinterface

// ----- sv/asp_ram.sv -----
// ============================================================================
// asp_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module asp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- sv/asp_param_store.sv -----
// ============================================================================
// asp_param_store
// CSI parameter store: a RAM plus one valid bit per entry, so that a new
// sequence clears the whole list at once. Reads beyond the list or of
// entries not yet written return zero.
// ============================================================================
module asp_param_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  asp_pkg::store_cmd_t      cmd,
    input  logic [$clog2(DEPTH):0]   rd_addr,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);
    import asp_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int KW = AW + 1;

    logic [DEPTH-1:0] valid_reg;
    logic             rd_zero_reg;
    logic [WIDTH-1:0] ram_rd_data;

    asp_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // Valid bits: cleared together at sequence start, set entry by entry on write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_zero_reg <= 1'b1;
        end
        else
        begin
            if (cmd.clear)
            begin
                valid_reg <= '0;
            end
            else if (cmd.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_zero_reg <= (rd_addr >= KW'(DEPTH)) ? 1'b1 : !valid_reg[rd_addr[AW-1:0]];
        end
    end

    // An invalid or out-of-range entry reads as zero.
    assign rd_data = rd_zero_reg ? '0 : ram_rd_data;

endmodule

// ----- sv/asp_out_reg.sv -----
// ============================================================================
// asp_out_reg
// Output register of the glyph channel: holds one word until it is taken.
// ============================================================================
module asp_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  asp_pkg::glyph_t  word_in,
    output logic             free,
    asp_glyph_if.source      glyph_out
);
    import asp_pkg::*;

    logic   valid_reg;
    glyph_t word_reg;

    // Valid flag: set on load, cleared once the word has been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (glyph_out.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_in;
        end
    end

    assign free                  = !valid_reg || glyph_out.ready;
    assign glyph_out.valid       = valid_reg;
    assign glyph_out.glyph_code  = word_reg.glyph_code;
    assign glyph_out.fore_colour = word_reg.fore_colour;
    assign glyph_out.back_colour = word_reg.back_colour;

endmodule

// ----- sv/ansi_sgr_color_parser_top.sv -----
// ============================================================================
// ansi_sgr_color_parser_top
// Console byte filter: tracks ESC / CSI state, collects SGR parameters in a
// RAM and keeps the current foreground and background colours.
// ============================================================================
//
//   Port       Dir   Payload                                 Word
//   text_in    in    text_byte[7:0]                          one console byte
//   glyph_out  out   glyph_code[7:0], fore/back_colour[31:0] glyph to draw
//
// An ordinary byte, ESC, ';' or the byte after ESC is handled in S_IDLE alone. A
// digit also passes through S_DIGIT: the parameter entry is read from the RAM,
// multiplied by ten and written back. 'm' starts the walk over the parameter
// list: S_CODE for a plain code, S_CODE and S_MODE for a 38 or 48 not followed
// by 2, and S_CODE, S_MODE, S_RED, S_GREEN and S_BLUE for each 38;2;r;g;b or
// 48;2;r;g;b group; the single RAM read port serves one entry at a time.
// Reset clears the valid bits of the parameter store at once; there is no
// clearing pass. A stalled glyph_out holds off text_in while its word waits.
module ansi_sgr_color_parser_top #(
    parameter int NUM_PARAMS = 16,
    parameter int PARAM_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    asp_byte_if.sink    text_in,
    asp_glyph_if.source glyph_out
);
    import asp_pkg::*;

    localparam int AW = $clog2(NUM_PARAMS);
    localparam int KW = AW + 1;
    localparam int EW = PARAM_BITS + 4;
    localparam logic [EW-1:0] PARAM_MAX = {4'b0, {PARAM_BITS{1'b1}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIGIT,
        S_CODE,
        S_MODE,
        S_RED,
        S_GREEN,
        S_BLUE
    } state_t;

    state_t              state_reg, state_next;
    logic                esc_reg, esc_next;
    logic                in_seq_reg, in_seq_next;
    logic [AW-1:0]       pidx_reg, pidx_next;
    logic [COLOUR_W-1:0] fore_reg, fore_next;
    logic [COLOUR_W-1:0] back_reg, back_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [3:0]          digit_reg, digit_next;
    logic                is_back_reg, is_back_next;
    logic [7:0]          red_reg, red_next;
    logic [7:0]          green_reg, green_next;

    store_cmd_t          store_cmd;
    logic [KW-1:0]       rd_addr;
    logic [PARAM_BITS-1:0] rd_data;
    logic [PARAM_BITS-1:0] wr_data;
    logic                out_free;
    logic                out_load;
    glyph_t              out_word;
    logic                accept;
    logic                advance;
    logic [KW-1:0]       k_adv;
    logic [EW-1:0]       acc_sum;
    logic [COLOUR_W-1:0] rgb_colour;
    logic [BYTE_W-1:0]   c;
    logic                is_digit;

    asp_param_store #(
        .DEPTH (NUM_PARAMS),
        .WIDTH (PARAM_BITS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (store_cmd),
        .rd_addr (rd_addr),
        .wr_addr (pidx_reg),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    asp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .word_in   (out_word),
        .free      (out_free),
        .glyph_out (glyph_out)
    );

    // Handshake and decoding of the incoming byte.
    assign text_in.ready = (state_reg == S_IDLE) && out_free;
    assign accept        = text_in.valid && text_in.ready;
    assign c             = text_in.text_byte;
    assign is_digit      = (c >= DIGIT_ZERO) && (c <= DIGIT_NINE);

    // Decimal accumulation: entry * 10 + digit, saturated to the field maximum.
    assign acc_sum = ({4'b0, rd_data} << 3) + ({4'b0, rd_data} << 1) + EW'(digit_reg);
    assign wr_data = (acc_sum > PARAM_MAX) ? {PARAM_BITS{1'b1}} : acc_sum[PARAM_BITS-1:0];

    // Truecolour word assembled from the three colour entries.
    assign rgb_colour = OPAQUE_ARGB | {8'h00, red_reg, green_reg, rd_data[7:0]};

    assign out_word.glyph_code  = c;
    assign out_word.fore_colour = fore_reg;
    assign out_word.back_colour = back_reg;

    // Sequencer: byte decoding, parameter read-modify-write and the SGR walk.
    // Only one access to the store is in flight at a time, so a digit write
    // always lands before the next read is issued.
    always_comb
    begin
        state_next   = state_reg;
        esc_next     = esc_reg;
        in_seq_next  = in_seq_reg;
        pidx_next    = pidx_reg;
        fore_next    = fore_reg;
        back_next    = back_reg;
        k_next       = k_reg;
        digit_next   = digit_reg;
        is_back_next = is_back_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        store_cmd    = '0;
        rd_addr      = '0;
        out_load     = 1'b0;
        advance      = 1'b0;
        k_adv        = k_reg + KW'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        if (c == CSI_OPEN)
                        begin
                            in_seq_next     = 1'b1;
                            pidx_next       = '0;
                            store_cmd.clear = 1'b1;
                        end
                    end
                    else if (in_seq_reg && is_digit)
                    begin
                        rd_addr    = KW'(pidx_reg);
                        digit_next = c[3:0];
                        state_next = S_DIGIT;
                    end
                    else if (in_seq_reg && (c == PARAM_SEP))
                    begin
                        if (pidx_reg != AW'(NUM_PARAMS - 1))
                        begin
                            pidx_next = pidx_reg + AW'(1);
                        end
                    end
                    else if (in_seq_reg && (c == SGR_FINAL))
                    begin
                        in_seq_next = 1'b0;
                        k_next      = '0;
                        rd_addr     = '0;
                        state_next  = S_CODE;
                    end
                    else if (c == ESC_CODE)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        out_load = 1'b1;
                    end
                end
            end

            S_DIGIT:
            begin
                store_cmd.wr_en = 1'b1;
                state_next      = S_IDLE;
            end

            S_CODE:
            begin
                priority if (rd_data == PARAM_BITS'(SGR_RESET))
                begin
                    fore_next = WHITE_ARGB;
                    back_next = BLACK_ARGB;
                    advance   = 1'b1;
                end
                else if ((rd_data == PARAM_BITS'(SGR_FORE)) ||
                         (rd_data == PARAM_BITS'(SGR_BACK)))
                begin
                    is_back_next = (rd_data == PARAM_BITS'(SGR_BACK));
                    rd_addr      = k_reg + KW'(1);
                    state_next   = S_MODE;
                end
                else
                begin
                    advance = 1'b1;
                end
            end

            S_MODE:
            begin
                if (rd_data == PARAM_BITS'(SGR_RGB))
                begin
                    rd_addr    = k_reg + KW'(2);
                    state_next = S_RED;
                end
                else
                begin
                    advance = 1'b1;
                end
            end

            S_RED:
            begin
                red_next   = rd_data[7:0];
                rd_addr    = k_reg + KW'(3);
                state_next = S_GREEN;
            end

            S_GREEN:
            begin
                green_next = rd_data[7:0];
                rd_addr    = k_reg + KW'(4);
                state_next = S_BLUE;
            end

            S_BLUE:
            begin
                if (is_back_reg)
                begin
                    back_next = rgb_colour;
                end
                else
                begin
                    fore_next = rgb_colour;
                end
                k_adv   = k_reg + KW'(5);
                advance = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Step to the next code, or finish once the current parameter index is passed.
        if (advance)
        begin
            k_next = k_adv;
            if (k_adv <= KW'(pidx_reg))
            begin
                rd_addr    = k_adv;
                state_next = S_CODE;
            end
            else
            begin
                state_next = S_IDLE;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            esc_reg     <= 1'b0;
            in_seq_reg  <= 1'b0;
            pidx_reg    <= '0;
            fore_reg    <= WHITE_ARGB;
            back_reg    <= BLACK_ARGB;
            k_reg       <= '0;
            is_back_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            esc_reg     <= esc_next;
            in_seq_reg  <= in_seq_next;
            pidx_reg    <= pidx_next;
            fore_reg    <= fore_next;
            back_reg    <= back_next;
            k_reg       <= k_next;
            is_back_reg <= is_back_next;
        end
    end

    // Working values of the walk and the digit path need no reset.
    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        red_reg   <= red_next;
        green_reg <= green_next;
    end

    // A digit inside a sequence is always followed by its write-back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !esc_reg && in_seq_reg && is_digit) |=> store_cmd.wr_en)
    else $error("digit accepted without a parameter write-back");

    // The sequence is closed for the whole of the SGR walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_DIGIT) |-> !in_seq_reg)
    else $error("sequence still open during the SGR walk");

    // Each code read by the walk lies within the collected parameters.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CODE) |-> (k_reg <= KW'(pidx_reg)))
    else $error("SGR walk beyond the parameter index");

    // The parameter index saturates at the last slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        pidx_reg <= AW'(NUM_PARAMS - 1))
    else $error("parameter index beyond the last slot");

endmodule

// ----- tb/tb.sv -----
// ============================================================================
// tb
// Self-checking bench for the ANSI SGR colour parser. A scoreboard class
// tracks the escape state, the CSI parameter slots and the current colours.
// It predicts every glyph word from the accepted text bytes and compares each
// glyph word that leaves the block, field by field. The stimulus is a short
// directed set followed by random SGR sequences, plain text and broken
// sequences. Both channels idle at random.
// ============================================================================
module tb;
    import asp_pkg::*;

    localparam int N_SLOTS      = 16;
    localparam int SLOT_BITS    = 16;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 2 * (N_SLOTS + 5) + 10;
    localparam int RANDOM_BYTES = 1450;

    // Colour tracker and the queue of glyph words it has predicted.
    class glyph_scoreboard;
        logic                 esc_seen;
        logic                 csi_open;
        int unsigned          slot;
        logic [SLOT_BITS-1:0] slot_value [N_SLOTS];
        logic [COLOUR_W-1:0]  fore_now;
        logic [COLOUR_W-1:0]  back_now;
        glyph_t               expected_glyphs [$];
        int                   fail_count;

        function new();
            esc_seen   = 1'b0;
            csi_open   = 1'b0;
            slot       = 0;
            foreach (slot_value[i]) slot_value[i] = '0;
            fore_now   = WHITE_ARGB;
            back_now   = BLACK_ARGB;
            fail_count = 0;
        endfunction

        // Slots past the end of the store read as zero.
        function logic [SLOT_BITS-1:0] entry_at(int unsigned k);
            return (k < N_SLOTS) ? slot_value[k] : '0;
        endfunction

        function logic [COLOUR_W-1:0] packed_rgb(int unsigned k);
            logic [SLOT_BITS-1:0] r;
            logic [SLOT_BITS-1:0] g;
            logic [SLOT_BITS-1:0] b;
            r = entry_at(k);
            g = entry_at(k + 1);
            b = entry_at(k + 2);
            return OPAQUE_ARGB | {8'h00, r[7:0], g[7:0], b[7:0]};
        endfunction

        // Walk the collected codes when the final 'm' arrives.
        function void apply_colour_codes();
            int unsigned          k;
            logic [SLOT_BITS-1:0] code;
            k = 0;
            while (k <= slot && k < N_SLOTS)
            begin
                code = slot_value[k];
                if (code == SGR_RESET)
                begin
                    fore_now = WHITE_ARGB;
                    back_now = BLACK_ARGB;
                end
                else if (code == SGR_FORE && entry_at(k + 1) == SGR_RGB)
                begin
                    fore_now = packed_rgb(k + 2);
                    k += 4;
                end
                else if (code == SGR_BACK && entry_at(k + 1) == SGR_RGB)
                begin
                    back_now = packed_rgb(k + 2);
                    k += 4;
                end
                k++;
            end
        endfunction

        // Advance the tracker by one accepted text byte.
        function void note_byte(logic [BYTE_W-1:0] b);
            longint unsigned acc;
            glyph_t          word;
            if (esc_seen)
            begin
                if (b == CSI_OPEN)
                begin
                    csi_open = 1'b1;
                    slot     = 0;
                    foreach (slot_value[i]) slot_value[i] = '0;
                end
                esc_seen = 1'b0;
                return;
            end
            if (csi_open)
            begin
                if (b >= DIGIT_ZERO && b <= DIGIT_NINE)
                begin
                    acc = longint'(slot_value[slot]) * 10 + longint'(b - DIGIT_ZERO);
                    if (acc > {SLOT_BITS{1'b1}})
                        acc = {SLOT_BITS{1'b1}};
                    slot_value[slot] = acc[SLOT_BITS-1:0];
                    return;
                end
                if (b == PARAM_SEP)
                begin
                    if (slot < N_SLOTS - 1)
                        slot++;
                    return;
                end
                if (b == SGR_FINAL)
                begin
                    apply_colour_codes();
                    csi_open = 1'b0;
                    return;
                end
            end
            if (b == ESC_CODE)
            begin
                esc_seen = 1'b1;
                return;
            end
            word.glyph_code  = b;
            word.fore_colour = fore_now;
            word.back_colour = back_now;
            expected_glyphs.push_back(word);
        endfunction

        // Compare one glyph word from the block with the oldest prediction.
        function void check_glyph(glyph_t got);
            glyph_t want;
            if (expected_glyphs.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected glyph word, expected none, actual %h %h %h",
                         $time, got.glyph_code, got.fore_colour, got.back_colour);
                return;
            end
            want = expected_glyphs.pop_front();
            if (got.glyph_code !== want.glyph_code)
            begin
                fail_count++;
                $display("%0t: glyph_code mismatch, expected %h, actual %h",
                         $time, want.glyph_code, got.glyph_code);
            end
            if (got.fore_colour !== want.fore_colour)
            begin
                fail_count++;
                $display("%0t: fore_colour mismatch, expected %h, actual %h",
                         $time, want.fore_colour, got.fore_colour);
            end
            if (got.back_colour !== want.back_colour)
            begin
                fail_count++;
                $display("%0t: back_colour mismatch, expected %h, actual %h",
                         $time, want.back_colour, got.back_colour);
            end
        endfunction

        function int pending();
            return expected_glyphs.size();
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   steady_flow = 1'b0;
    int   sent_count  = 0;
    int   idle_cycles = 0;

    asp_byte_if  text_if ();
    asp_glyph_if glyph_if ();

    glyph_scoreboard sb = new();

    ansi_sgr_color_parser_top #(
        .NUM_PARAMS (N_SLOTS),
        .PARAM_BITS (SLOT_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_if),
        .glyph_out (glyph_if)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sample both channels between edges; also watch for a stalled run.
    always @(negedge clk)
    begin
        glyph_t seen;
        if (rst_n)
        begin
            if (text_if.valid && text_if.ready)
                sb.note_byte(text_if.text_byte);
            if (glyph_if.valid && glyph_if.ready)
            begin
                seen.glyph_code  = glyph_if.glyph_code;
                seen.fore_colour = glyph_if.fore_colour;
                seen.back_colour = glyph_if.back_colour;
                sb.check_glyph(seen);
            end
            if ((text_if.valid && text_if.ready) || (glyph_if.valid && glyph_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Glyph receiver: a random stall before each word.
    initial
    begin
        int stall;
        glyph_if.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                glyph_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            glyph_if.ready <= 1'b1;
            do @(negedge clk); while (!(glyph_if.valid && glyph_if.ready));
            @(posedge clk);
        end
    end

    // Offer one text byte after a random gap and wait until it is taken.
    task automatic drive_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            text_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_if.valid     <= 1'b1;
        text_if.text_byte <= b;
        do @(negedge clk); while (!(text_if.valid && text_if.ready));
        @(posedge clk);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            drive_byte(s[i]);
    endtask

    // ESC followed by the given bytes.
    task automatic send_csi(input string s);
        drive_byte(ESC_CODE);
        send_text(s);
    endtask

    // Hold the sender off until every predicted glyph word has come out.
    task automatic drain_glyphs();
        text_if.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Colour level: mostly a byte, sometimes wider, now and then saturating.
    function automatic int colour_level();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(256, 999);
            1:       return $urandom_range(65536, 999999);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // One SGR parameter group, possibly empty.
    function automatic string sgr_group();
        case ($urandom_range(0, 7))
            0:    return "0";
            1, 2: return $sformatf("38;2;%0d;%0d;%0d",
                                   colour_level(), colour_level(), colour_level());
            3, 4: return $sformatf("48;2;%0d;%0d;%0d",
                                   colour_level(), colour_level(), colour_level());
            5:    return $sformatf("%0d;5;%0d", ($urandom_range(0, 1) != 0) ? 38 : 48,
                                   $urandom_range(0, 255));
            6:    return $sformatf("%0d", $urandom_range(0, 120));
            default: return "";
        endcase
    endfunction

    // Main stimulus.
    initial
    begin
        string params;
        int    target;
        int    n;
        text_if.valid     <= 1'b0;
        text_if.text_byte <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes on the reset colours.
        drive_byte(8'h00);
        drive_byte(8'hFF);
        // Truecolour foreground with a red level past eight bits.
        send_csi("[38;2;300;0;128mA");
        // Truecolour background, then an explicit reset.
        send_csi("[48;2;1;2;3mB");
        send_csi("[0mC");
        // Both colours in one sequence, then an empty list which resets.
        send_csi("[38;2;9;8;7;48;2;6;5;4mD");
        send_csi("[mE");
        // A byte after ESC other than '[' is dropped, as is a second ESC.
        send_csi("xF");
        drive_byte(ESC_CODE);
        drive_byte(ESC_CODE);
        drive_byte("G");
        // A parameter that saturates.
        send_csi("[38;2;99999999;1;1mH");
        // A stray byte inside CSI is drawn and the sequence stays open.
        send_csi("[38;2;1;2A3;4mI");
        // The slot index saturates; entries past the store read as zero.
        send_csi("[;;;;;;;;;;;;;;38;2mJ");
        send_csi("[;;;;;;;;;;;;;;;;;;;;1;48;2mK");
        // ESC inside CSI restarts the sequence; an indexed colour is ignored.
        send_csi("[38;2;1");
        send_csi("[48;2;7;7;7mL");
        send_csi("[38;5;200mM");
        // Sequence characters outside CSI are ordinary glyphs.
        send_text("m;9[");

        // Let everything come out before the random part starts.
        drain_glyphs();

        // Random: mostly well-formed sequences, the rest noise and broken ones.
        target = sent_count + RANDOM_BYTES;
        while (sent_count < target)
        begin
            if ($urandom_range(0, 19) == 0)
                steady_flow = !steady_flow;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    params = sgr_group();
                    n = $urandom_range(0, 4);
                    repeat (n) params = {params, ";", sgr_group()};
                    send_csi({"[", params, "m"});
                    repeat ($urandom_range(1, 4)) drive_byte(8'($urandom_range(32, 126)));
                end
                5, 6:
                begin
                    repeat ($urandom_range(1, 5)) drive_byte(8'($urandom_range(0, 255)));
                end
                7:
                begin
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            drive_byte(ESC_CODE);
                            drive_byte(8'($urandom_range(0, 255)));
                        end
                        1:
                        begin
                            send_csi({"[", sgr_group()});
                            drive_byte(8'($urandom_range(0, 255)));
                        end
                        default:
                        begin
                            send_csi({"[", sgr_group(), ";"});
                            send_csi({"[", sgr_group(), "m"});
                        end
                    endcase
                    drive_byte(8'($urandom_range(32, 126)));
                end
                8:
                begin
                    params = sgr_group();
                    n = $urandom_range(12, 22);
                    repeat (n) params = {params, ";", sgr_group()};
                    send_csi({"[", params, "m"});
                    drive_byte(8'($urandom_range(32, 126)));
                end
                default:
                begin
                    send_csi($sformatf("[%0d;2;%0d;%0d;%0dm",
                                       ($urandom_range(0, 1) != 0) ? 38 : 48,
                                       $urandom(), $urandom(), $urandom()));
                    drive_byte(8'($urandom_range(32, 126)));
                end
            endcase
        end

        // Wait for the last glyph words, then a little longer.
        text_if.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
